@@ rtl/core/centered_window_average_core_assert.svh @@
// Assertion macros for the centered window average core.
// Self-contained; included by the core, the RTL file that carries assertions.
`ifndef CENTERED_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define CENTERED_WINDOW_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, gated off during reset
`define CWA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset
`define CWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cwa_pkg.sv @@
// Shared constants and types for the centered window average core.
// No dependencies; used by the core, the checker and the bench.
package cwa_pkg;

    localparam int RADIUS_W        = 5;
    localparam int AVG_W           = 16;
    localparam int MAX_RADIUS_DEF  = 31;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_EMIT,
        ST_FLUSH
    } t_state;

endpackage

@@ rtl/core/cwa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample ring of the core.
module cwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/centered_window_average_core.sv @@
// Centered moving average over a sample stream, with bit-serial divider.
// Depends on cwa_pkg, cwa_ram and centered_window_average_core_assert.svh.
//
// Each accepted sample beat goes into a ring memory and updates a running
// window sum; the sum is then divided by 2*radius+1 in a restoring divider
// that retires one quotient bit per cycle. A sample beat with a full window
// keeps the core busy while it updates the sum, retires every quotient bit
// and hands the result over, and a stalled result register holds it longer;
// the next sample beat is taken only once the core is back in idle, so the
// serial divider sets the spacing of sample beats and a new sample is not
// taken before the last one is through. Positions without a full window skip
// the divider. On the last sample the trailing positions leave as no-average
// beats, one per cycle while the output is not stalled, before the next sample
// is taken. Writing radius restarts the array; the config port is ready only when idle.
`include "centered_window_average_core_assert.svh"

module centered_window_average_core #(
    parameter int MAX_RADIUS  = cwa_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cwa_pkg::RADIUS_W-1:0] i_cfg_radius,
    // sample input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_last_sample,
    // result output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_has_average,
    output logic [cwa_pkg::AVG_W-1:0]    o_average,
    output logic                         o_last_result
);

    localparam int AW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int DEPTH = 2 ** AW;
    localparam int SUM_W = SAMPLE_BITS + AW;
    localparam int CNT_W = $clog2(SUM_W);
    localparam logic [cwa_pkg::RADIUS_W-1:0] MaxR  = cwa_pkg::RADIUS_W'(MAX_RADIUS);
    localparam logic [CNT_W-1:0]             DivLast = CNT_W'(SUM_W - 1);

    cwa_pkg::t_state r_state, n_state;

    logic [cwa_pkg::RADIUS_W-1:0] r_radius, n_radius;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic [AW-1:0]                r_seen, n_seen;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic [SAMPLE_BITS-1:0]       r_sample, n_sample;
    logic                         r_last, n_last;
    logic                         r_sub, n_sub;
    logic                         r_res_has, n_res_has;
    logic                         r_res_fin, n_res_fin;
    logic [AW-1:0]                r_flush_cnt, n_flush_cnt;
    logic [SUM_W-1:0]             r_div, n_div;
    logic [AW-1:0]                r_rem, n_rem;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_has, n_out_has;
    logic [cwa_pkg::AVG_W-1:0]    r_out_avg, n_out_avg;
    logic                         r_out_fin, n_out_fin;

    logic [cwa_pkg::RADIUS_W-1:0] r_eff;
    logic [AW-1:0]                r_eff_aw;
    logic [AW-1:0]                win;
    logic [AW-1:0]                seen_inc;
    logic [SUM_W-1:0]             sum_upd;
    logic [AW:0]                  rem_sh;
    logic [AW:0]                  rem_diff;
    logic                         rem_ge;
    logic                         in_acc;
    logic                         cfg_acc;
    logic                         slot_free;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [SAMPLE_BITS-1:0]       ram_rdata;

    // clamp radius and form the window length
    assign r_eff    = (r_radius > MaxR) ? MaxR : r_radius;
    assign r_eff_aw = {1'b0, r_eff[AW-2:0]};
    assign win      = {r_eff[AW-2:0], 1'b1};

    // handshakes: config takes priority over a sample in the same cycle
    assign o_cfg_ready = (r_state == cwa_pkg::ST_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != cwa_pkg::ST_IDLE) || i_cfg_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;

    // ring write at the pointer, read of the sample leaving the window
    assign ram_we    = in_acc;
    assign ram_raddr = r_ptr - win;

    cwa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (i_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window sum update and saturating sample count
    assign sum_upd  = r_sum + SUM_W'(r_sample) - (r_sub ? SUM_W'(ram_rdata) : '0);
    assign seen_inc = (r_seen == '1) ? r_seen : r_seen + AW'(1);

    // one restoring division step
    assign rem_sh   = {r_rem, r_div[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, win};
    assign rem_ge   = (rem_sh >= {1'b0, win});

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwa_pkg::ST_IDLE;
            r_radius    <= '0;
            r_sum       <= '0;
            r_seen      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radius    <= n_radius;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
        r_sample    <= n_sample;
        r_last      <= n_last;
        r_sub       <= n_sub;
        r_res_has   <= n_res_has;
        r_res_fin   <= n_res_fin;
        r_flush_cnt <= n_flush_cnt;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_out_has   <= n_out_has;
        r_out_avg   <= n_out_avg;
        r_out_fin   <= n_out_fin;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_radius    = r_radius;
        n_sum       = r_sum;
        n_seen      = r_seen;
        n_ptr       = r_ptr;
        n_sample    = r_sample;
        n_last      = r_last;
        n_sub       = r_sub;
        n_res_has   = r_res_has;
        n_res_fin   = r_res_fin;
        n_flush_cnt = r_flush_cnt;
        n_div       = r_div;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_has   = r_out_has;
        n_out_avg   = r_out_avg;
        n_out_fin   = r_out_fin;

        case (r_state)
            cwa_pkg::ST_IDLE: begin
                // take a radius write and restart the array, or take a sample
                if (cfg_acc) begin
                    n_radius = i_cfg_radius;
                    n_sum    = '0;
                    n_seen   = '0;
                    n_ptr    = '0;
                end else if (in_acc) begin
                    n_sample = i_sample;
                    n_last   = i_last_sample;
                    n_sub    = (r_seen >= win);
                    n_state  = cwa_pkg::ST_SUM;
                end
            end
            cwa_pkg::ST_SUM: begin
                // advance the window and decide which beats this sample yields
                n_div     = sum_upd;
                n_rem     = '0;
                n_cnt     = '0;
                n_res_has = (seen_inc >= win);
                n_res_fin = r_last && (r_eff_aw == '0);
                if (seen_inc > r_eff_aw) begin
                    n_flush_cnt = r_eff_aw;
                    n_state     = (seen_inc >= win) ? cwa_pkg::ST_DIV : cwa_pkg::ST_EMIT;
                end else begin
                    n_flush_cnt = seen_inc;
                    n_state     = r_last ? cwa_pkg::ST_FLUSH : cwa_pkg::ST_IDLE;
                end
                if (r_last) begin
                    n_sum  = '0;
                    n_seen = '0;
                    n_ptr  = '0;
                end else begin
                    n_sum  = sum_upd;
                    n_seen = seen_inc;
                    n_ptr  = r_ptr + AW'(1);
                end
            end
            cwa_pkg::ST_DIV: begin
                // shift one quotient bit in per cycle
                n_rem = rem_ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
                n_div = {r_div[SUM_W-2:0], rem_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == DivLast) begin
                    n_state = cwa_pkg::ST_EMIT;
                end
            end
            cwa_pkg::ST_EMIT: begin
                // drop the centered result into the output register
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_has   = r_res_has;
                    n_out_avg   = r_res_has ? cwa_pkg::AVG_W'(r_div) : '0;
                    n_out_fin   = r_res_fin;
                    n_state     = (r_last && (r_flush_cnt != '0)) ?
                                  cwa_pkg::ST_FLUSH : cwa_pkg::ST_IDLE;
                end
            end
            cwa_pkg::ST_FLUSH: begin
                // give the trailing positions as no-average beats
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_has   = 1'b0;
                    n_out_avg   = '0;
                    n_out_fin   = (r_flush_cnt == AW'(1));
                    n_flush_cnt = r_flush_cnt - AW'(1);
                    if (r_flush_cnt == AW'(1)) begin
                        n_state = cwa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = cwa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_has_average = r_out_has;
    assign o_average     = r_out_avg;
    assign o_last_result = r_out_fin;

    // checks on the sample accept, the divider, the flush counter and the stream clear
    `CWA_ASSERT_NEXT(a_acc_to_sum, i_clk, i_rst_n, in_acc, r_state == cwa_pkg::ST_SUM,
                     "accepted sample did not move to sum")
    `CWA_ASSERT_SAME(a_rem_below_win, i_clk, i_rst_n, r_state == cwa_pkg::ST_DIV,
                     r_rem < win, "divider remainder not below window length")
    `CWA_ASSERT_SAME(a_flush_nonzero, i_clk, i_rst_n, r_state == cwa_pkg::ST_FLUSH,
                     r_flush_cnt != '0, "flush count empty while flushing")
    `CWA_ASSERT_SAME(a_clear_after_flush, i_clk, i_rst_n,
                     r_state == cwa_pkg::ST_IDLE && $past(r_state) == cwa_pkg::ST_FLUSH,
                     r_seen == '0 && r_sum == '0, "stream state not cleared after last beat")

endmodule

@@ bench/centered_window_average_checker.sv @@
// Watches the config, sample and result channels of the centered window average core.
// Predicts every result beat and compares it with what the core gives.
// Depends on cwa_pkg.
module centered_window_average_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [cwa_pkg::RADIUS_W-1:0] i_cfg_radius,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [15:0]                  i_sample,
    input  logic                         i_last_sample,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_has_average,
    input  logic [cwa_pkg::AVG_W-1:0]    i_average,
    input  logic                         i_last_result,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      has_avg;
        logic [cwa_pkg::AVG_W-1:0] avg;
        logic                      last;
    } t_avg_beat;

    // Predicted core state
    logic [cwa_pkg::RADIUS_W-1:0] half_width;
    logic [15:0]                  window_ring [64];
    logic [21:0]                  window_total;
    logic [5:0]                   array_count;
    logic [5:0]                   write_slot;
    t_avg_beat                    expected_averages [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        half_width   = '0;
        window_total = '0;
        array_count  = '0;
        write_slot   = '0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic restart_array();
        window_total = '0;
        array_count  = '0;
        write_slot   = '0;
    endtask

    // Advance the window by one sample and queue the result beats it releases
    task automatic predict_window(input logic [15:0] value, input logic is_last);
        logic [5:0] span;
        logic [5:0] old_slot;
        t_avg_beat  beat;
        span     = {half_width, 1'b1};
        old_slot = write_slot - span;
        window_ring[write_slot] = value;
        window_total = window_total + value;
        if (array_count >= span) begin
            window_total = window_total - window_ring[old_slot];
        end
        write_slot = write_slot + 6'd1;
        if (array_count != 6'd63) begin
            array_count = array_count + 6'd1;
        end
        if (array_count > half_width) begin
            beat.has_avg = (array_count >= span);
            beat.avg     = beat.has_avg ? cwa_pkg::AVG_W'(window_total / span) : '0;
            beat.last    = is_last && (half_width == 0);
            expected_averages.push_back(beat);
            if (is_last) begin
                for (int j = 0; j < half_width; j++) begin
                    expected_averages.push_back('{1'b0, '0, j == half_width - 1});
                end
            end
        end else if (is_last) begin
            // array shorter than the trailing distance: flush every position
            for (int j = 0; j < array_count; j++) begin
                expected_averages.push_back('{1'b0, '0, j == array_count - 1});
            end
        end
        if (is_last) begin
            restart_array();
        end
    endtask

    always @(posedge i_clk) begin
        t_avg_beat want;
        if (!i_rst_n) begin
            half_width = '0;
            restart_array();
            expected_averages.delete();
        end else begin
            // radius write restarts the array
            if (i_cfg_valid && i_cfg_ready) begin
                half_width = i_cfg_radius;
                restart_array();
            end
            // check the result beat against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 1, 0);
                end else begin
                    want = expected_averages.pop_front();
                    if (i_has_average !== want.has_avg)
                        report_mismatch("has_average", i_has_average, want.has_avg);
                    if (i_average !== want.avg)
                        report_mismatch("average", i_average, want.avg);
                    if (i_last_result !== want.last)
                        report_mismatch("last_result", i_last_result, want.last);
                end
            end
            // predict from the accepted sample beat
            if (i_in_valid && !i_in_stall) begin
                predict_window(i_sample, i_last_sample);
            end
        end
        o_pending = expected_averages.size();
    end

endmodule

@@ bench/tb.sv @@
// Top of the centered window average regression: clock, reset, stimulus, verdict.
// Depends on cwa_pkg, centered_window_average_core and centered_window_average_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [cwa_pkg::RADIUS_W-1:0] cfg_radius = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [15:0]                  sample = '0;
    logic                         last_sample = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         has_average;
    logic [cwa_pkg::AVG_W-1:0]    average;
    logic                         last_result;
    int                           fail_count;
    int                           pending;

    // Traffic shaping shared by the sender and the receiver
    int   in_idle_pct = 34;
    int   out_idle_pct = 64;
    int   samples_sent = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    centered_window_average_core i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_radius (cfg_radius),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample     (sample),
        .i_last_sample(last_sample),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_has_average(has_average),
        .o_average    (average),
        .o_last_result(last_result)
    );

    centered_window_average_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_radius (cfg_radius),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample     (sample),
        .i_last_sample(last_sample),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_has_average(has_average),
        .i_average    (average),
        .i_last_result(last_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the core hangs
    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_stall = 1'b1;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            out_stall = ($urandom_range(0, 99) < out_idle_pct);
        end
    end

    // Offer one sample beat and hold it until accepted; called at a falling edge
    task automatic send_sample(input logic [15:0] value, input logic is_last);
        if (samples_sent >= 210) begin
            in_idle_pct  = 0;
            out_idle_pct = 0;
        end else if (samples_sent >= 105) begin
            in_idle_pct  = 64;
            out_idle_pct = 34;
        end
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        sample      = value;
        last_sample = is_last;
        do @(posedge clk); while (in_stall);
        samples_sent++;
        @(negedge clk);
    endtask

    // Send an array of random samples, extremes mixed in
    task automatic send_array(input int len, input logic with_last);
        logic [15:0] value;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                default: value = 16'($urandom_range(0, 65535));
            endcase
            send_sample(value, with_last && (i == len - 1));
        end
    endtask

    // Write radius once the core has drained
    task automatic load_radius(input logic [cwa_pkg::RADIUS_W-1:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid  = 1'b1;
        cfg_radius = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        logic [cwa_pkg::RADIUS_W-1:0] r;
        int                           len;
        int                           kind;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Pass-through at radius 0, sample extremes
        load_radius(0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        // Radius 1 with full windows, then a one-sample array
        load_radius(1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h1234, 1'b1);
        // Largest radius on an array too short to reach the first result
        load_radius(31);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b1);
        // Window wider than the array: all positions without average
        load_radius(2);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'hFF00, 1'b0);
        send_sample(16'h5555, 1'b1);
        // Radius write in the middle of an array starts a new one
        send_array(4, 1'b0);
        load_radius(3);
        send_array(5, 1'b1);

        // Full windows at the largest radius, past the count saturation;
        // hold the receiver off meanwhile so the core backs up into its input
        load_radius(31);
        hold_req = 1'b1;
        send_array(66, 1'b1);

        // Random arrays under random radius settings
        r = 3;
        load_radius(r);
        while (samples_sent < 310) begin
            if ($urandom_range(0, 99) < 20) begin
                case ($urandom_range(0, 9))
                    0:       r = 31;
                    1, 2:    r = cwa_pkg::RADIUS_W'($urandom_range(0, 31));
                    default: r = cwa_pkg::RADIUS_W'($urandom_range(0, 4));
                endcase
                load_radius(r);
            end
            kind = $urandom_range(0, 99);
            if (r == 31) begin
                send_array($urandom_range(1, 68), 1'b1);
            end else if (kind < 70) begin
                send_array($urandom_range(1, 2 * r + 6), 1'b1);
            end else if (kind < 82) begin
                send_array($urandom_range(1, r + 1), 1'b1);
            end else if (kind < 85) begin
                send_array($urandom_range(64, 72), 1'b1);
            end else begin
                // abandon the array and restart it with a radius write
                len = $urandom_range(1, 2 * r + 4);
                send_array(len, 1'b0);
                load_radius(r);
            end
        end

        // Drain and let the core settle
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
